/* rtl/pva_pkg.sv */
// Shared types and constants for the priority voice allocator.
`default_nettype none
package pva_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int PRIO_W       = 2;
    localparam int TICK_W       = 32;
    localparam int KIND_W       = 2;
    localparam int FIN_W        = 4;
    localparam int IDX_OUT_W    = 4;
    localparam int CNT_OUT_W    = 5;

    localparam logic [PRIO_W-1:0] PROT_PRIO_RST = 2'd3;

    localparam logic [KIND_W-1:0] KIND_PLAY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [PRIO_W-1:0]   request_priority;
        logic [TICK_W-1:0]   now_tick;
        logic [FIN_W-1:0]    finished_channel;
    } pva_in_t;

    typedef struct packed {
        logic                 granted;
        logic [IDX_OUT_W-1:0] channel_index;
        logic                 stolen;
        logic [CNT_OUT_W-1:0] active_count;
    } pva_out_t;

    // one channel's stored record
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] start;
    } chan_entry_t;

    // sequencer to selector
    typedef struct packed {
        logic clear;
        logic check;
        logic active;
    } sel_ctrl_t;

    // selector to sequencer
    typedef struct packed {
        logic found_idle;
        logic have_steal;
    } sel_stat_t;

endpackage
`default_nettype wire

/* rtl/priority_voice_allocator.sv */
// Priority voice allocator top level: sequencer, active bits and result register.
// Play request: one record is read per cycle from the channel memory, and the scan
//   ends early at the first idle one.
// Finish, stop-all and unused kinds: go straight to the done state, skipping the scan.
// A new item is accepted while a result waits; one item is in work at a time.
// Synchronous active-low reset clears all channels and sets protected priority to 3.
`default_nettype none
module priority_voice_allocator
    import pva_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [PRIO_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pva_in_t           s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pva_out_t               m_data
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GRANT,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CHANNELS-1:0] active_reg;
    logic [CW-1:0]       count_reg;
    logic [PRIO_W-1:0]   prot_reg;
    logic [PRIO_W-1:0]   req_prio_reg;
    logic [TICK_W-1:0]   req_tick_reg;
    logic [IW-1:0]       issue_reg;
    logic                issue_done_reg;
    logic                chk_vld_reg;
    logic [IW-1:0]       chk_idx_reg;
    logic                res_granted_reg;
    logic                res_stolen_reg;
    logic [IW-1:0]       res_idx_reg;
    logic                m_valid_reg;
    pva_out_t            m_data_reg;

    logic        accept;
    logic        rd_en;
    logic        wr_en;
    logic        fin_ok;
    logic [IW-1:0] fin_idx;
    chan_entry_t wr_data;
    chan_entry_t rd_data;
    sel_ctrl_t   sel_ctrl;
    sel_stat_t   sel_stat;
    logic [IW-1:0] pick;
    logic        chk_active;
    logic        scan_end;
    logic        grant_ok;
    logic        out_load;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    assign fin_ok  = 32'(s_data.finished_channel) < CHANNELS;
    assign fin_idx = IW'(s_data.finished_channel);

    assign rd_en      = (state_reg == S_SCAN) && !issue_done_reg;
    assign chk_active = active_reg[chk_idx_reg];

    assign sel_ctrl.clear  = accept;
    assign sel_ctrl.check  = chk_vld_reg && (state_reg == S_SCAN);
    assign sel_ctrl.active = chk_active;

    // first idle channel ends the scan; otherwise the last record does
    assign scan_end = sel_ctrl.check && (!chk_active || chk_idx_reg == LAST_IDX);
    assign grant_ok = sel_stat.found_idle || sel_stat.have_steal;

    assign wr_en         = (state_reg == S_GRANT) && grant_ok;
    assign wr_data.prio  = req_prio_reg;
    assign wr_data.start = req_tick_reg;

    // result register takes a new beat when empty or draining
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    pva_chan_mem #(
        .CHANNELS (CHANNELS),
        .IW       (IW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pick),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg),
        .rd_data (rd_data)
    );

    pva_selector #(
        .CHANNELS (CHANNELS),
        .IW       (IW)
    ) u_sel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (sel_ctrl),
        .idx       (chk_idx_reg),
        .entry     (rd_data),
        .req_prio  (req_prio_reg),
        .prot_prio (prot_reg),
        .stat      (sel_stat),
        .pick      (pick)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            count_reg      <= '0;
            prot_reg       <= PROT_PRIO_RST;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                prot_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg              <= 1'b1;
                m_data_reg.granted       <= res_granted_reg;
                m_data_reg.channel_index <= IDX_OUT_W'(res_idx_reg);
                m_data_reg.stolen        <= res_stolen_reg;
                m_data_reg.active_count  <= CNT_OUT_W'(count_reg);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            chk_vld_reg <= rd_en;
            chk_idx_reg <= issue_reg;
            if (rd_en) begin
                issue_reg <= issue_reg + 1'b1;
                if (issue_reg == LAST_IDX) begin
                    issue_done_reg <= 1'b1;
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_prio_reg    <= s_data.request_priority;
                        req_tick_reg    <= s_data.now_tick;
                        res_granted_reg <= 1'b0;
                        res_stolen_reg  <= 1'b0;
                        res_idx_reg     <= '0;
                        issue_reg       <= '0;
                        issue_done_reg  <= 1'b0;
                        case (s_data.kind)
                            KIND_PLAY: begin
                                state_reg <= S_SCAN;
                            end
                            KIND_FINISH: begin
                                state_reg <= S_DONE;
                                if (fin_ok && active_reg[fin_idx]) begin
                                    active_reg[fin_idx] <= 1'b0;
                                    count_reg           <= count_reg - 1'b1;
                                end
                            end
                            KIND_STOP: begin
                                state_reg  <= S_DONE;
                                active_reg <= '0;
                                count_reg  <= '0;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_end) begin
                        state_reg <= S_GRANT;
                    end
                end
                S_GRANT: begin
                    res_granted_reg <= grant_ok;
                    res_stolen_reg  <= !sel_stat.found_idle && sel_stat.have_steal;
                    res_idx_reg     <= grant_ok ? pick : '0;
                    if (grant_ok) begin
                        active_reg[pick] <= 1'b1;
                    end
                    if (sel_stat.found_idle) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CHANNELS)
        else $error("active count above pool size");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.granted |-> m_data.channel_index == '0 && !m_data.stolen)
        else $error("refused beat carries channel or steal");

    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.kind == KIND_STOP |=> count_reg == '0 && active_reg == '0)
        else $error("stop-all left channels active");

    a_steal_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_data.stolen |-> 32'(count_reg) == CHANNELS)
        else $error("steal with an idle channel present");

endmodule
`default_nettype wire

/* rtl/pva_chan_mem.sv */
// Channel record memory: one write port, one registered read port.
`default_nettype none
module pva_chan_mem
    import pva_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire chan_entry_t   wr_data,
    input  wire logic          rd_en,
    input  wire logic [IW-1:0] rd_addr,
    output chan_entry_t        rd_data
);

    chan_entry_t mem [CHANNELS];
    chan_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/pva_selector.sv */
// Shared compare unit: walks channel records and keeps the pick.
`default_nettype none
module pva_selector
    import pva_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sel_ctrl_t         ctrl,
    input  wire logic [IW-1:0]     idx,
    input  wire chan_entry_t       entry,
    input  wire logic [PRIO_W-1:0] req_prio,
    input  wire logic [PRIO_W-1:0] prot_prio,
    output sel_stat_t              stat,
    output logic [IW-1:0]          pick
);

    logic              found_reg, found_next;
    logic              have_reg, have_next;
    logic [IW-1:0]     pick_reg, pick_next;
    logic [TICK_W-1:0] best_reg, best_next;
    logic              eligible;
    logic              older;

    assign eligible = (entry.prio != prot_prio) && (entry.prio <= req_prio);
    assign older    = !have_reg || (entry.start < best_reg);

    always_comb begin
        found_next = found_reg;
        have_next  = have_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (ctrl.clear) begin
            found_next = 1'b0;
            have_next  = 1'b0;
        end else if (ctrl.check && !found_reg) begin
            if (!ctrl.active) begin
                found_next = 1'b1;
                pick_next  = idx;
            end else if (eligible && older) begin
                have_next = 1'b1;
                pick_next = idx;
                best_next = entry.start;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            have_reg  <= 1'b0;
        end else begin
            found_reg <= found_next;
            have_reg  <= have_next;
        end
        pick_reg <= pick_next;
        best_reg <= best_next;
    end

    assign stat.found_idle = found_reg;
    assign stat.have_steal = have_reg;
    assign pick            = pick_reg;

endmodule
`default_nettype wire

/* sim/priority_voice_allocator_test.sv */
// Testbench for priority_voice_allocator: directed and random voice traffic against a predictor.
`timescale 1ns / 1ps
module priority_voice_allocator_test;
    import pva_pkg::*;

    localparam int CHANNELS = CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [PRIO_W-1:0] cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pva_in_t           s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pva_out_t          m_data;

    priority_voice_allocator #(
        .CHANNELS(CHANNELS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // predictor copy of the channel pool
    logic              pool_active [CHANNELS];
    logic [PRIO_W-1:0] pool_prio   [CHANNELS];
    logic [TICK_W-1:0] pool_start  [CHANNELS];
    logic [PRIO_W-1:0] guarded_level = PROT_PRIO_RST;

    pva_out_t pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int plays_seen = 0;
    int steals_seen = 0;
    int refusals_seen = 0;
    int finishes_seen = 0;
    int stops_seen = 0;
    logic [TICK_W-1:0] tick_clock = '0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL priority_voice_allocator");
        $finish;
    end

    task automatic predict_voice_result(input pva_in_t beat, output pva_out_t res);
        int pick;
        int n;
        logic steal;
        logic [TICK_W-1:0] best;
        res = '0;
        pick = -1;
        steal = 1'b0;
        best = '0;
        case (beat.kind)
            KIND_PLAY: begin
                plays_seen++;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (!pool_active[i] && pick < 0) pick = i;
                end
                if (pick < 0) begin
                    // pool full: oldest eligible start wins, lowest index on ties
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (pool_prio[i] != guarded_level && pool_prio[i] <= beat.request_priority
                                && (pick < 0 || pool_start[i] < best)) begin
                            pick = i;
                            best = pool_start[i];
                        end
                    end
                    steal = (pick >= 0);
                end
                if (pick >= 0) begin
                    pool_active[pick] = 1'b1;
                    pool_prio[pick] = beat.request_priority;
                    pool_start[pick] = beat.now_tick;
                    res.granted = 1'b1;
                    res.channel_index = 4'(pick);
                    res.stolen = steal;
                    if (steal) steals_seen++;
                end else begin
                    refusals_seen++;
                end
            end
            KIND_FINISH: begin
                finishes_seen++;
                pool_active[beat.finished_channel] = 1'b0;
            end
            KIND_STOP: begin
                stops_seen++;
                for (int i = 0; i < CHANNELS; i++) begin
                    pool_active[i] = 1'b0;
                    pool_prio[i] = '0;
                    pool_start[i] = '0;
                end
            end
            default: ;
        endcase
        n = 0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (pool_active[i]) n++;
        end
        res.active_count = 5'(n);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        pva_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %h", m_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, m_data.granted);
                    mismatch_count++;
                end
                if (m_data.channel_index !== want.channel_index) begin
                    $error("channel_index: expected %0d, got %0d",
                           want.channel_index, m_data.channel_index);
                    mismatch_count++;
                end
                if (m_data.stolen !== want.stolen) begin
                    $error("stolen: expected %0d, got %0d", want.stolen, m_data.stolen);
                    mismatch_count++;
                end
                if (m_data.active_count !== want.active_count) begin
                    $error("active_count: expected %0d, got %0d",
                           want.active_count, m_data.active_count);
                    mismatch_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Called right after an edge; leaves valid high after the accepting edge.
    task automatic send_beat(input pva_in_t beat);
        pva_out_t res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_voice_result(beat, res);
        pending_results.push_back(res);
    endtask

    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (CHANNELS + 8) @(posedge aclk);
    endtask

    task automatic write_protected_level(input logic [PRIO_W-1:0] level);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= level;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        guarded_level = level;
    endtask

    function automatic pva_in_t make_beat(input logic [KIND_W-1:0] kind,
                                          input logic [PRIO_W-1:0] prio,
                                          input logic [TICK_W-1:0] tick,
                                          input logic [FIN_W-1:0] fin);
        pva_in_t b;
        b.kind = kind;
        b.request_priority = prio;
        b.now_tick = tick;
        b.finished_channel = fin;
        return b;
    endfunction

    function automatic pva_in_t random_voice_event();
        int roll;
        int tick_roll;
        pva_in_t b;
        roll = $urandom_range(0, 99);
        tick_roll = $urandom_range(0, 9);
        if (roll < 70) b.kind = KIND_PLAY;
        else if (roll < 92) b.kind = KIND_FINISH;
        else if (roll < 93) b.kind = KIND_STOP;
        else if (roll < 96) b.kind = KIND_UNUSED;
        else b.kind = KIND_PLAY;
        b.request_priority = 2'($urandom_range(0, 3));
        b.finished_channel = 4'($urandom_range(0, 15));
        // mostly a rising clock with frequent equal ticks, some wild values
        if (tick_roll < 8) begin
            tick_clock = tick_clock + 32'($urandom_range(0, 3));
            b.now_tick = tick_clock;
        end else if (tick_roll == 8) begin
            b.now_tick = $urandom();
        end else begin
            b.now_tick = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        return b;
    endfunction

    task automatic test_empty_pool();
        send_beat(make_beat(KIND_STOP, 2'd3, 32'hFFFF_FFFF, 4'd0));
        send_beat(make_beat(KIND_UNUSED, 2'd3, 32'hFFFF_FFFF, 4'd15));
        send_beat(make_beat(KIND_FINISH, 2'd0, 32'h0, 4'd15));
    endtask

    task automatic test_fill_and_steal();
        logic [TICK_W-1:0] tick;
        for (int i = 0; i < CHANNELS; i++) begin
            case (i)
                0: tick = 32'hFFFF_FFFF;
                1, 3: tick = 32'h0;       // channel 3 ties channel 1 as oldest but is protected
                4, 8: tick = 32'd5;       // tie among lowest priority
                12: tick = 32'd7;
                default: tick = 32'h100 + 32'(i);
            endcase
            send_beat(make_beat(KIND_PLAY, 2'(i % 4), tick, 4'(15 - i)));
        end
        send_beat(make_beat(KIND_PLAY, 2'd0, 32'h200, 4'd0));
        send_beat(make_beat(KIND_PLAY, 2'd3, 32'h201, 4'd0));
        send_beat(make_beat(KIND_FINISH, 2'd3, 32'hFFFF_FFFF, 4'd9));
        send_beat(make_beat(KIND_PLAY, 2'd2, 32'h202, 4'd15));
    endtask

    task automatic test_protected_levels();
        wait_for_quiet();
        write_protected_level(2'd0);
        // for the level-0 play only level-0 channels are eligible, and they are all guarded
        send_beat(make_beat(KIND_PLAY, 2'd0, 32'h300, 4'd0));
        send_beat(make_beat(KIND_PLAY, 2'd1, 32'h301, 4'd0));
        send_beat(make_beat(KIND_STOP, 2'd0, 32'h0, 4'd0));
        wait_for_quiet();
        write_protected_level(2'd3);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        logic [PRIO_W-1:0] level;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int c = 0; c < 5; c++) begin
            if (c == 0) level = 2'd0;
            else if (c == 1) level = 2'd3;
            else level = 2'($urandom_range(0, 3));
            wait_for_quiet();
            write_protected_level(level);
            repeat (68) send_beat(random_voice_event());
        end
    endtask

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            pool_active[i] = 1'b0;
            pool_prio[i] = '0;
            pool_start[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 10;
        recv_idle_pct = 87;
        test_empty_pool();
        test_fill_and_steal();
        test_protected_levels();

        test_random_traffic(10, 87);
        test_random_traffic(87, 10);
        test_random_traffic(0, 0);

        wait_for_quiet();
        $display("Covered %0d plays (%0d steals, %0d refused), %0d finishes, %0d stop-alls",
                 plays_seen, steals_seen, refusals_seen, finishes_seen, stops_seen);
        $display("under protected levels 0 to 3 and three stall regimes, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS priority_voice_allocator");
        end else begin
            $display("FAIL priority_voice_allocator");
        end
        $finish;
    end

endmodule
